>>> src/ppu_pkg.sv
// Shared types, constants and datapath command codes of the particle pool update unit.
package ppu_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int STEPS     = 32;

    localparam logic [30:0]        MAX_AGE_RST = 31'd655360;
    localparam logic signed [31:0] LEFT_RST    = 32'sd0;
    localparam logic signed [31:0] RIGHT_RST   = 32'sd20447232;
    localparam logic signed [31:0] TOP_RST     = 32'sd0;
    localparam logic signed [31:0] BOTTOM_RST  = 32'sd15466496;

    typedef enum logic [2:0] {
        CFG_MAX_AGE = 3'd0,
        CFG_LEFT    = 3'd1,
        CFG_RIGHT   = 3'd2,
        CFG_TOP     = 3'd3,
        CFG_BOTTOM  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_SPAWNED = 3'd0,
        ST_FULL    = 3'd1,
        ST_MOVED   = 3'd2,
        ST_EXPIRED = 3'd3,
        ST_OFFSCR  = 3'd4,
        ST_NONE    = 3'd5
    } t_status;

    typedef enum logic {
        OPC_SPAWN = 1'b0,
        OPC_TICK  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic               op;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] speed_scale;
        logic signed [31:0] drag_rate;
        logic [30:0]        tick_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         slot;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [6:0]         live_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] speed;
        logic signed [31:0] drag;
        logic [31:0]        age;
    } t_rec;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_IDX_INC,
        OP_SPAWN,
        OP_FULL,
        OP_LATCH,
        OP_EXPIRE,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_RED_MUL,
        OP_RED_SET,
        OP_NUM,
        OP_VZERO,
        OP_SC_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_MV_MUL1,
        OP_MV_SAT,
        OP_MV_MUL2,
        OP_MV_ADD,
        OP_WB,
        OP_NONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] comp;
    } t_dp_cmd;

    typedef struct packed {
        logic active_here;
        logic idx_last;
        logic more_above;
        logic expired;
        logic drag_on;
        logic cur_gt_red;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SP_SCAN,
        S_TK_SCAN,
        S_TK_LATCH,
        S_TK_AGE,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQ_INIT,
        S_SQ_STEP,
        S_RED_MUL,
        S_RED_SET,
        S_DRAG_CHK,
        S_SC_MUL,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_DONE,
        S_MV_MUL1,
        S_MV_SAT,
        S_MV_MUL2,
        S_MV_ADD,
        S_WB,
        S_NEXT
    } t_state;

endpackage

>>> src/ppu_ctrl.sv
// Sequencing state machine of the particle pool update unit.
module ppu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  ppu_pkg::t_dp_stat i_stat,
    output ppu_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    ppu_pkg::t_state r_state, n_state;
    logic [4:0]      r_cnt;
    logic [1:0]      r_comp;
    logic            r_any;
    ppu_pkg::t_dp_op cmd_op;

    logic comp_end, cnt_end;
    assign comp_end = (r_comp == 2'd2);
    assign cnt_end  = (r_cnt == 5'(ppu_pkg::STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppu_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_op == ppu_pkg::OPC_TICK) ? ppu_pkg::S_TK_SCAN
                                                          : ppu_pkg::S_SP_SCAN;
                end
            end
            ppu_pkg::S_SP_SCAN: begin
                if (!i_stat.active_here || i_stat.idx_last) begin
                    n_state = ppu_pkg::S_IDLE;
                end
            end
            ppu_pkg::S_TK_SCAN:  n_state = i_stat.active_here ? ppu_pkg::S_TK_LATCH
                                                              : ppu_pkg::S_NEXT;
            ppu_pkg::S_TK_LATCH: n_state = ppu_pkg::S_TK_AGE;
            ppu_pkg::S_TK_AGE: begin
                if (i_stat.expired)      n_state = ppu_pkg::S_NEXT;
                else if (i_stat.drag_on) n_state = ppu_pkg::S_SQ_MUL;
                else                     n_state = ppu_pkg::S_MV_MUL1;
            end
            ppu_pkg::S_SQ_MUL:  n_state = ppu_pkg::S_SQ_ACC;
            ppu_pkg::S_SQ_ACC:  n_state = comp_end ? ppu_pkg::S_SQ_INIT : ppu_pkg::S_SQ_MUL;
            ppu_pkg::S_SQ_INIT: n_state = ppu_pkg::S_SQ_STEP;
            ppu_pkg::S_SQ_STEP: n_state = cnt_end ? ppu_pkg::S_RED_MUL : ppu_pkg::S_SQ_STEP;
            ppu_pkg::S_RED_MUL: n_state = ppu_pkg::S_RED_SET;
            ppu_pkg::S_RED_SET: n_state = ppu_pkg::S_DRAG_CHK;
            ppu_pkg::S_DRAG_CHK: n_state = i_stat.cur_gt_red ? ppu_pkg::S_SC_MUL
                                                            : ppu_pkg::S_MV_MUL1;
            ppu_pkg::S_SC_MUL:   n_state = ppu_pkg::S_DIV_INIT;
            ppu_pkg::S_DIV_INIT: n_state = ppu_pkg::S_DIV_STEP;
            ppu_pkg::S_DIV_STEP: n_state = cnt_end ? ppu_pkg::S_DIV_DONE : ppu_pkg::S_DIV_STEP;
            ppu_pkg::S_DIV_DONE: n_state = comp_end ? ppu_pkg::S_MV_MUL1 : ppu_pkg::S_SC_MUL;
            ppu_pkg::S_MV_MUL1:  n_state = ppu_pkg::S_MV_SAT;
            ppu_pkg::S_MV_SAT:   n_state = ppu_pkg::S_MV_MUL2;
            ppu_pkg::S_MV_MUL2:  n_state = ppu_pkg::S_MV_ADD;
            ppu_pkg::S_MV_ADD:   n_state = comp_end ? ppu_pkg::S_WB : ppu_pkg::S_MV_MUL1;
            ppu_pkg::S_WB:       n_state = ppu_pkg::S_NEXT;
            ppu_pkg::S_NEXT:     n_state = i_stat.idx_last ? ppu_pkg::S_IDLE
                                                           : ppu_pkg::S_TK_SCAN;
            default:             n_state = ppu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd_op = ppu_pkg::OP_NOP;
        unique case (r_state)
            ppu_pkg::S_IDLE:     if (i_start) cmd_op = ppu_pkg::OP_CAPTURE;
            ppu_pkg::S_SP_SCAN: begin
                if (!i_stat.active_here)  cmd_op = ppu_pkg::OP_SPAWN;
                else if (i_stat.idx_last) cmd_op = ppu_pkg::OP_FULL;
                else                      cmd_op = ppu_pkg::OP_IDX_INC;
            end
            ppu_pkg::S_TK_SCAN:  cmd_op = ppu_pkg::OP_NOP;
            ppu_pkg::S_TK_LATCH: cmd_op = ppu_pkg::OP_LATCH;
            ppu_pkg::S_TK_AGE:   if (i_stat.expired) cmd_op = ppu_pkg::OP_EXPIRE;
            ppu_pkg::S_SQ_MUL:   cmd_op = ppu_pkg::OP_SQ_MUL;
            ppu_pkg::S_SQ_ACC:   cmd_op = ppu_pkg::OP_SQ_ACC;
            ppu_pkg::S_SQ_INIT:  cmd_op = ppu_pkg::OP_SQ_INIT;
            ppu_pkg::S_SQ_STEP:  cmd_op = ppu_pkg::OP_SQ_STEP;
            ppu_pkg::S_RED_MUL:  cmd_op = ppu_pkg::OP_RED_MUL;
            ppu_pkg::S_RED_SET:  cmd_op = ppu_pkg::OP_RED_SET;
            ppu_pkg::S_DRAG_CHK: cmd_op = i_stat.cur_gt_red ? ppu_pkg::OP_NUM
                                                           : ppu_pkg::OP_VZERO;
            ppu_pkg::S_SC_MUL:   cmd_op = ppu_pkg::OP_SC_MUL;
            ppu_pkg::S_DIV_INIT: cmd_op = ppu_pkg::OP_DIV_INIT;
            ppu_pkg::S_DIV_STEP: cmd_op = ppu_pkg::OP_DIV_STEP;
            ppu_pkg::S_DIV_DONE: cmd_op = ppu_pkg::OP_DIV_DONE;
            ppu_pkg::S_MV_MUL1:  cmd_op = ppu_pkg::OP_MV_MUL1;
            ppu_pkg::S_MV_SAT:   cmd_op = ppu_pkg::OP_MV_SAT;
            ppu_pkg::S_MV_MUL2:  cmd_op = ppu_pkg::OP_MV_MUL2;
            ppu_pkg::S_MV_ADD:   cmd_op = ppu_pkg::OP_MV_ADD;
            ppu_pkg::S_WB:       cmd_op = ppu_pkg::OP_WB;
            ppu_pkg::S_NEXT: begin
                if (!i_stat.idx_last) cmd_op = ppu_pkg::OP_IDX_INC;
                else if (!r_any)      cmd_op = ppu_pkg::OP_NONE;
            end
            default:             cmd_op = ppu_pkg::OP_NOP;
        endcase
    end

    assign o_cmd.op   = cmd_op;
    assign o_cmd.comp = r_comp;
    assign o_busy     = (r_state != ppu_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppu_pkg::S_IDLE;
            r_cnt   <= '0;
            r_comp  <= '0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ppu_pkg::S_IDLE) begin
                r_any <= 1'b0;
            end else if (cmd_op == ppu_pkg::OP_EXPIRE || cmd_op == ppu_pkg::OP_WB) begin
                r_any <= 1'b1;
            end
            if (r_state == ppu_pkg::S_SQ_INIT || r_state == ppu_pkg::S_DIV_INIT) begin
                r_cnt <= '0;
            end else if (r_state == ppu_pkg::S_SQ_STEP || r_state == ppu_pkg::S_DIV_STEP) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (r_state == ppu_pkg::S_TK_AGE || r_state == ppu_pkg::S_DRAG_CHK) begin
                r_comp <= '0;
            end else if (r_state == ppu_pkg::S_SQ_ACC || r_state == ppu_pkg::S_DIV_DONE
                         || r_state == ppu_pkg::S_MV_ADD) begin
                r_comp <= comp_end ? 2'd0 : r_comp + 2'd1;
            end
        end
    end

endmodule

>>> src/ppu_dp.sv
// Datapath of the particle pool update unit: slot memory, shared multiplier, root and divider.
module ppu_dp #(
    parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppu_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  ppu_pkg::t_dp_cmd    i_cmd,
    output ppu_pkg::t_dp_stat   o_stat,
    output logic                o_valid,
    output ppu_pkg::t_out_item  o_result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    function automatic logic signed [47:0] div16(input logic signed [63:0] x);
        logic signed [47:0] t;
        t = x[63:16];
        if (x[63] && (x[15:0] != 16'd0)) t = t + 48'sd1;
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
        if (x > 49'sh0_7FFF_FFFF)       return 32'sh7FFF_FFFF;
        else if (x < -49'sh0_8000_0000) return 32'sh8000_0000;
        else                            return x[31:0];
    endfunction

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Configuration registers.
    logic [30:0]        r_max_age;
    logic signed [31:0] r_left, r_right, r_top, r_bottom;

    ppu_pkg::t_in_item  r_in;
    ppu_pkg::t_rec      mem [SLOTS];
    ppu_pkg::t_rec      r_rd, r_rec, wrec, lat_rec;
    logic               mem_we;

    logic [SLOTS-1:0]   r_active;
    logic [6:0]         r_live;
    logic [IW-1:0]      r_idx;

    logic signed [63:0] r_prod;
    logic [63:0]        r_acc, r_rem, r_res, r_bit;
    logic [31:0]        r_cur, r_num, r_drem, r_dlo;
    logic [45:0]        r_red;
    logic signed [31:0] r_ws;

    logic               r_valid;
    ppu_pkg::t_out_item r_out, n_out;

    ppu_pkg::t_dp_op    op;
    logic signed [31:0] vc, pc;
    logic [31:0]        vmag;
    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p;
    logic [63:0]        sq_sum;
    logic [32:0]        dv_t;
    logic [32:0]        age_sum;
    logic               offscr;
    logic [SLOTS-1:0]   above;

    assign op = i_cmd.op;

    always_comb begin
        unique case (i_cmd.comp)
            2'd0:    begin vc = r_rec.vx; pc = r_rec.px; end
            2'd1:    begin vc = r_rec.vy; pc = r_rec.py; end
            default: begin vc = r_rec.vz; pc = r_rec.pz; end
        endcase
    end
    assign vmag = mag(vc);

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (op)
            ppu_pkg::OP_SQ_MUL:  begin m_a = {1'b0, vmag}; m_b = {1'b0, vmag}; end
            ppu_pkg::OP_RED_MUL: begin m_a = {r_rec.drag[31], r_rec.drag};
                                       m_b = {2'b00, r_in.tick_time}; end
            ppu_pkg::OP_SC_MUL:  begin m_a = {1'b0, vmag}; m_b = {1'b0, r_num}; end
            ppu_pkg::OP_MV_MUL1: begin m_a = {vc[31], vc};
                                       m_b = {r_rec.speed[31], r_rec.speed}; end
            ppu_pkg::OP_MV_MUL2: begin m_a = {r_ws[31], r_ws};
                                       m_b = {2'b00, r_in.tick_time}; end
            default:             begin m_a = '0; m_b = '0; end
        endcase
    end
    assign m_p    = m_a * m_b;
    assign sq_sum = r_res + r_bit;
    assign dv_t   = {r_drem, r_dlo[31]};

    assign age_sum = {1'b0, r_rd.age} + {2'b00, r_in.tick_time};
    assign offscr  = (r_rec.px < r_left) || (r_rec.px > r_right) ||
                     (r_rec.py < r_top)  || (r_rec.py > r_bottom);
    assign above   = (r_active >> r_idx) >> 1;

    assign o_stat.active_here = r_active[r_idx];
    assign o_stat.idx_last    = (r_idx == IW'(SLOTS - 1));
    assign o_stat.more_above  = |above;
    assign o_stat.expired     = (r_rec.age >= {1'b0, r_max_age});
    assign o_stat.drag_on     = (r_rec.drag > 32'sd0);
    assign o_stat.cur_gt_red  = ({14'd0, r_cur} > r_red);

    // The slot record as it is taken for a tick, with its age already advanced.
    always_comb begin
        lat_rec     = r_rd;
        lat_rec.age = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    end

    always_comb begin
        wrec = r_rec;
        if (op == ppu_pkg::OP_SPAWN) begin
            wrec.px    = r_in.start_x;
            wrec.py    = r_in.start_y;
            wrec.pz    = r_in.start_z;
            wrec.vx    = r_in.dir_x;
            wrec.vy    = r_in.dir_y;
            wrec.vz    = r_in.dir_z;
            wrec.speed = r_in.speed_scale;
            wrec.drag  = r_in.drag_rate;
            wrec.age   = '0;
        end
    end
    assign mem_we = (op == ppu_pkg::OP_SPAWN) || (op == ppu_pkg::OP_WB);

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_idx] <= wrec;
        r_rd <= mem[r_idx];
    end

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= ppu_pkg::MAX_AGE_RST;
            r_left    <= ppu_pkg::LEFT_RST;
            r_right   <= ppu_pkg::RIGHT_RST;
            r_top     <= ppu_pkg::TOP_RST;
            r_bottom  <= ppu_pkg::BOTTOM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppu_pkg::CFG_MAX_AGE: r_max_age <= i_cfg_data[30:0];
                ppu_pkg::CFG_LEFT:    r_left    <= i_cfg_data;
                ppu_pkg::CFG_RIGHT:   r_right   <= i_cfg_data;
                ppu_pkg::CFG_TOP:     r_top     <= i_cfg_data;
                ppu_pkg::CFG_BOTTOM:  r_bottom  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state of the pool.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_live   <= '0;
            r_idx    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= (op == ppu_pkg::OP_SPAWN) || (op == ppu_pkg::OP_FULL) ||
                       (op == ppu_pkg::OP_EXPIRE) || (op == ppu_pkg::OP_WB) ||
                       (op == ppu_pkg::OP_NONE);
            if (op == ppu_pkg::OP_CAPTURE) r_idx <= '0;
            if (op == ppu_pkg::OP_IDX_INC) r_idx <= r_idx + IW'(1);
            if (op == ppu_pkg::OP_SPAWN) begin
                r_active[r_idx] <= 1'b1;
                r_live          <= r_live + 7'd1;
            end
            if (op == ppu_pkg::OP_EXPIRE || (op == ppu_pkg::OP_WB && offscr)) begin
                r_active[r_idx] <= 1'b0;
                r_live          <= r_live - 7'd1;
            end
        end
    end

    // Result payload for the command of this cycle.
    always_comb begin
        n_out            = '0;
        n_out.slot       = 6'(r_idx);
        n_out.out_x      = r_rec.px;
        n_out.out_y      = r_rec.py;
        n_out.out_z      = r_rec.pz;
        n_out.live_count = r_live;
        n_out.last       = 1'b1;
        case (op)
            ppu_pkg::OP_SPAWN: begin
                n_out.status     = ppu_pkg::ST_SPAWNED;
                n_out.out_x      = r_in.start_x;
                n_out.out_y      = r_in.start_y;
                n_out.out_z      = r_in.start_z;
                n_out.live_count = r_live + 7'd1;
            end
            ppu_pkg::OP_EXPIRE: begin
                n_out.status     = ppu_pkg::ST_EXPIRED;
                n_out.live_count = r_live - 7'd1;
                n_out.last       = ~o_stat.more_above;
            end
            ppu_pkg::OP_WB: begin
                n_out.status     = offscr ? ppu_pkg::ST_OFFSCR : ppu_pkg::ST_MOVED;
                n_out.live_count = offscr ? r_live - 7'd1 : r_live;
                n_out.last       = ~o_stat.more_above;
            end
            default: begin
                n_out.status = (op == ppu_pkg::OP_NONE) ? ppu_pkg::ST_NONE
                                                        : ppu_pkg::ST_FULL;
                n_out.slot   = '0;
                n_out.out_x  = '0;
                n_out.out_y  = '0;
                n_out.out_z  = '0;
            end
        endcase
    end

    // Arithmetic and result register.
    always_ff @(posedge i_clk) begin
        if (op == ppu_pkg::OP_CAPTURE) r_in <= i_item;
        unique case (op)
            ppu_pkg::OP_SQ_MUL, ppu_pkg::OP_RED_MUL, ppu_pkg::OP_SC_MUL,
            ppu_pkg::OP_MV_MUL1, ppu_pkg::OP_MV_MUL2: r_prod <= m_p[63:0];
            default: ;
        endcase
        case (op)
            ppu_pkg::OP_LATCH: begin
                r_rec <= lat_rec;
                r_acc <= '0;
            end
            ppu_pkg::OP_SQ_ACC:  r_acc <= r_acc + r_prod;
            ppu_pkg::OP_SQ_INIT: begin
                r_rem <= r_acc;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            ppu_pkg::OP_SQ_STEP: begin
                if (r_rem >= sq_sum) begin
                    r_rem <= r_rem - sq_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ppu_pkg::OP_RED_SET: begin
                r_red <= r_prod[61:16];
                r_cur <= r_res[31:0];
            end
            ppu_pkg::OP_NUM:   r_num <= r_cur - r_red[31:0];
            ppu_pkg::OP_VZERO: begin
                r_rec.vx <= '0;
                r_rec.vy <= '0;
                r_rec.vz <= '0;
            end
            ppu_pkg::OP_DIV_INIT: begin
                r_drem <= r_prod[63:32];
                r_dlo  <= r_prod[31:0];
            end
            ppu_pkg::OP_DIV_STEP: begin
                if (dv_t >= {1'b0, r_cur}) begin
                    r_drem <= 32'(dv_t - {1'b0, r_cur});
                    r_dlo  <= {r_dlo[30:0], 1'b1};
                end else begin
                    r_drem <= dv_t[31:0];
                    r_dlo  <= {r_dlo[30:0], 1'b0};
                end
            end
            ppu_pkg::OP_DIV_DONE: begin
                unique case (i_cmd.comp)
                    2'd0:    r_rec.vx <= vc[31] ? 32'(-r_dlo) : r_dlo;
                    2'd1:    r_rec.vy <= vc[31] ? 32'(-r_dlo) : r_dlo;
                    default: r_rec.vz <= vc[31] ? 32'(-r_dlo) : r_dlo;
                endcase
            end
            ppu_pkg::OP_MV_SAT: r_ws <= sat32(49'(div16(r_prod)));
            ppu_pkg::OP_MV_ADD: begin
                unique case (i_cmd.comp)
                    2'd0:    r_rec.px <= sat32(49'(pc) + 49'(div16(r_prod)));
                    2'd1:    r_rec.py <= sat32(49'(pc) + 49'(div16(r_prod)));
                    default: r_rec.pz <= sat32(49'(pc) + 49'(div16(r_prod)));
                endcase
            end
            default: ;
        endcase

        r_out <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

>>> src/particle_pool_update_unit.sv
// Top level of the particle pool update unit: controller, datapath and checks.
//
//  channel   signals                              when taken
//  -------   -----------------------------------  ---------------------------------
//  item in   start, busy, i_item                  edge with start high and busy low
//  result    o_valid, o_result                    edge ending the o_valid cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data      edge with i_cfg_we high
//
// One item is worked at a time; busy may already be low while its final result shows.
// A spawn examines one slot at a time from slot 0, stopping at the first free one.
// A tick visits every slot in turn: an inactive or expiring slot is left at once, an active
// one is moved, and one with drag is first slowed using the serial square root (32 steps)
// and, unless it stops, the serial divider (32 steps for each of the three velocity components).
// Reset is synchronous and clears the active flags and the live count at once, with no
// clearing pass; the receiver cannot stall, and each result shows for exactly one cycle.
module particle_pool_update_unit #(
    parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ppu_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_valid,
    output ppu_pkg::t_out_item  o_result
);

    ppu_pkg::t_dp_cmd  cmd;
    ppu_pkg::t_dp_stat stat;

    // The controller sees start only when idle, so a start during busy is ignored.
    ppu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ppu_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

`ifndef SYNTHESIS
    // The live count never exceeds the pool size.
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.live_count <= 7'(SLOTS)))
        else $error("live count above pool size");

    // A successful spawn always leaves at least one slot live.
    a_spawn_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ppu_pkg::ST_SPAWNED) |-> (o_result.live_count != 7'd0))
        else $error("spawn reported an empty pool");

    // The final result of an item is never followed by another result in the next cycle.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> !o_valid)
        else $error("result directly after final result");

    // Intermediate results only come out while an item is being worked.
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> busy)
        else $error("intermediate result while idle");
`endif

endmodule

>>> dv/ppu_checker.sv
// Checker for the particle pool update unit: predicts results and compares them.
`timescale 1ns / 1ps

module ppu_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  ppu_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic                o_valid,
    input  ppu_pkg::t_out_item  o_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);

    localparam int NSLOT = ppu_pkg::SLOTS_DEF;

    logic [30:0]            lifetime;
    logic signed [31:0]     lim_left, lim_right, lim_top, lim_bottom;
    logic                   alive [NSLOT];
    ppu_pkg::t_rec          pool [NSLOT];
    int unsigned            alive_total;
    ppu_pkg::t_out_item     expected_results [$];

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] rem, res, bit_w;
        rem = n; res = 0; bit_w = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bit_w) begin
                rem = rem - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Truncating signed divide by 2^16 (toward zero), done on 64-bit values.
    function automatic logic signed [63:0] div16(input logic signed [63:0] v);
        return v / 64'sd65536;
    endfunction

    function automatic void push_result(input ppu_pkg::t_status st, input int idx,
                                        input logic signed [31:0] x, y, z);
        ppu_pkg::t_out_item r;
        r.status = st; r.slot = idx[5:0];
        r.out_x = x; r.out_y = y; r.out_z = z;
        r.live_count = alive_total[6:0]; r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_item(input ppu_pkg::t_in_item it);
        int free_idx, n;
        logic [63:0] tick, age_sum, red, sq, cur, q;
        logic signed [31:0] v [3];
        logic signed [31:0] p [3];
        logic signed [63:0] ws;
        tick = {33'd0, it.tick_time};
        n = 0;
        if (it.op == ppu_pkg::OPC_SPAWN) begin
            free_idx = -1;
            for (int i = 0; i < NSLOT; i++)
                if (!alive[i] && free_idx < 0) free_idx = i;
            if (free_idx < 0) begin
                push_result(ppu_pkg::ST_FULL, 0, 0, 0, 0);
            end else begin
                alive[free_idx] = 1'b1;
                alive_total++;
                pool[free_idx] = '{it.start_x, it.start_y, it.start_z, it.dir_x, it.dir_y,
                                   it.dir_z, it.speed_scale, it.drag_rate, 32'd0};
                push_result(ppu_pkg::ST_SPAWNED, free_idx, it.start_x, it.start_y,
                            it.start_z);
            end
            expected_results[$].last = 1'b1;
            return;
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (!alive[i]) continue;
            age_sum = {32'd0, pool[i].age} + tick;
            pool[i].age = age_sum > 64'hFFFFFFFF ? 32'hFFFFFFFF : age_sum[31:0];
            if (pool[i].age >= {1'b0, lifetime}) begin
                alive[i] = 1'b0;
                if (alive_total > 0) alive_total--;
                push_result(ppu_pkg::ST_EXPIRED, i, pool[i].px, pool[i].py, pool[i].pz);
                n++;
                continue;
            end
            v[0] = pool[i].vx; v[1] = pool[i].vy; v[2] = pool[i].vz;
            p[0] = pool[i].px; p[1] = pool[i].py; p[2] = pool[i].pz;
            if (pool[i].drag > 0) begin
                red = ({32'd0, pool[i].drag} * tick) >> 16;
                sq = 0;
                for (int c = 0; c < 3; c++) sq += mag(v[c]) * mag(v[c]);
                cur = floor_sqrt(sq);
                for (int c = 0; c < 3; c++) begin
                    if (cur > red) begin
                        q = mag(v[c]) * (cur - red) / cur;
                        v[c] = v[c] < 0 ? -q[31:0] : q[31:0];
                    end else begin
                        v[c] = '0;
                    end
                end
            end
            for (int c = 0; c < 3; c++) begin
                ws = clamp32(div16(64'(v[c]) * 64'(pool[i].speed)));
                p[c] = clamp32(64'(p[c]) + div16(ws * $signed(tick)));
            end
            pool[i].vx = v[0]; pool[i].vy = v[1]; pool[i].vz = v[2];
            pool[i].px = p[0]; pool[i].py = p[1]; pool[i].pz = p[2];
            if (p[0] < lim_left || p[0] > lim_right || p[1] < lim_top || p[1] > lim_bottom) begin
                alive[i] = 1'b0;
                if (alive_total > 0) alive_total--;
                push_result(ppu_pkg::ST_OFFSCR, i, p[0], p[1], p[2]);
            end else begin
                push_result(ppu_pkg::ST_MOVED, i, p[0], p[1], p[2]);
            end
            n++;
        end
        if (n == 0) push_result(ppu_pkg::ST_NONE, 0, 0, 0, 0);
        expected_results[$].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        ppu_pkg::t_out_item want;
        if (!i_rst_n) begin
            lifetime = ppu_pkg::MAX_AGE_RST;
            lim_left = ppu_pkg::LEFT_RST; lim_right = ppu_pkg::RIGHT_RST;
            lim_top = ppu_pkg::TOP_RST; lim_bottom = ppu_pkg::BOTTOM_RST;
            for (int i = 0; i < NSLOT; i++) alive[i] = 1'b0;
            alive_total = 0;
            expected_results.delete();
        end else begin
            // Results are checked before the item of this edge is predicted: a result
            // can never come out on the same edge as the item that causes it.
            if (o_valid) begin
                o_result_count++;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%t unexpected result %p", $realtime, o_result);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%t mismatch: expected %p, got %p",
                                     $realtime, want, o_result);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ppu_pkg::CFG_MAX_AGE: lifetime = i_cfg_data[30:0];
                    ppu_pkg::CFG_LEFT:    lim_left = i_cfg_data;
                    ppu_pkg::CFG_RIGHT:   lim_right = i_cfg_data;
                    ppu_pkg::CFG_TOP:     lim_top = i_cfg_data;
                    ppu_pkg::CFG_BOTTOM:  lim_bottom = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) predict_item(i_item);
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
    end
endmodule

>>> dv/tb_particle_pool_update_unit.sv
// Testbench top of the particle pool update unit: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_particle_pool_update_unit;

    // The watchdog counts cycles with no accepted item, no result and no register write. The
    // slowest gap falls within a tick over active slots with drag, so the limit is generous.
    localparam int IDLE_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 325;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    ppu_pkg::t_in_item   i_item = '0;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_idx = '0;
    logic [31:0]         i_cfg_data = '0;
    logic                o_valid;
    ppu_pkg::t_out_item  o_result;

    int fail_count, pending, result_count;
    int idle_cycles = 0;
    int items_sent = 0;
    int ticks_sent = 0;

    always #1 i_clk = ~i_clk;

    particle_pool_update_unit dut (.*);

    ppu_checker checker_inst (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .o_valid, .o_result,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Watchdog: any item, result or register write keeps the run alive.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d quiet cycles", IDLE_LIMIT);
                $display("tb_particle_pool_update_unit: FAIL");
                $finish;
            end
        end
    end

    // Presents one item and holds start until the edge that takes it. Start is only
    // lowered when the next item is not immediately queued behind it.
    task automatic send_item(input ppu_pkg::t_in_item it, input bit keep_start);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (it.op == ppu_pkg::OPC_TICK) ticks_sent++;
        if (!keep_start) start <= 1'b0;
    endtask

    // Waits until every expected result has come and the unit is no longer busy.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input ppu_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a well-formed spawn: on screen or just past its edge, modest velocity, sometimes with drag.
    function automatic ppu_pkg::t_in_item spawn_item();
        ppu_pkg::t_in_item it;
        it = '0;
        it.op = ppu_pkg::OPC_SPAWN;
        it.start_x = $urandom_range(0, 312) << 16 | $urandom_range(0, 65535);
        it.start_y = $urandom_range(0, 236) << 16 | $urandom_range(0, 65535);
        it.start_z = $urandom;
        it.dir_x = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        it.dir_y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        it.dir_z = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        it.speed_scale = $signed($urandom_range(0, 1 << 18)) - (1 << 16);
        it.drag_rate = ($urandom_range(0, 2) == 0) ? 0 : $signed($urandom_range(0, 1 << 18));
        it.tick_time = 31'($urandom);
        // Now and then a spawn with fully random content, reaching every bit.
        if ($urandom_range(0, 7) == 0) begin
            it.start_x = $urandom; it.start_y = $urandom;
            it.dir_x = $urandom; it.dir_y = $urandom; it.dir_z = $urandom;
            it.speed_scale = $urandom; it.drag_rate = $urandom;
        end
        return it;
    endfunction

    function automatic ppu_pkg::t_in_item tick_item();
        ppu_pkg::t_in_item it;
        it = '0;
        it.op = ppu_pkg::OPC_TICK;
        it.start_x = $urandom; it.drag_rate = $urandom;
        case ($urandom_range(0, 9))
            0:       it.tick_time = 31'($urandom);
            1:       it.tick_time = '0;
            default: it.tick_time = 31'($urandom_range(0, 1 << 15));
        endcase
        return it;
    endfunction

    initial begin
        ppu_pkg::t_in_item it;
        int burst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings. A tick on an empty pool reports
        // that nothing is active.
        it = '0; it.op = ppu_pkg::OPC_TICK; it.tick_time = 31'h7FFFFFFF;
        send_item(it, 0);
        // Extreme spawns: most negative and most positive fields, both off screen.
        it = '0; it.op = ppu_pkg::OPC_SPAWN;
        it.start_x = 32'sh80000000; it.start_y = 32'sh80000000; it.start_z = 32'sh80000000;
        it.dir_x = 32'sh80000000; it.dir_y = 32'sh80000000; it.dir_z = 32'sh80000000;
        it.speed_scale = 32'sh80000000; it.drag_rate = 32'sh80000000;
        send_item(it, 1);
        it.start_x = 32'sh7FFFFFFF; it.start_y = 32'sh7FFFFFFF; it.start_z = 32'sh7FFFFFFF;
        it.dir_x = 32'sh7FFFFFFF; it.dir_y = 32'sh7FFFFFFF; it.dir_z = 32'sh7FFFFFFF;
        it.speed_scale = 32'sh7FFFFFFF; it.drag_rate = 32'sh7FFFFFFF;
        it.tick_time = 31'h7FFFFFFF;
        send_item(it, 1);
        // On screen, drag strong enough to stop the particle, a weak drag, and no drag.
        it = '0; it.op = ppu_pkg::OPC_SPAWN;
        it.start_x = 100 << 16; it.start_y = 100 << 16;
        it.dir_x = 1 << 16; it.dir_y = -(1 << 16); it.speed_scale = 1 << 16;
        it.drag_rate = 100 << 16;
        send_item(it, 1);
        it.drag_rate = 1 << 10; it.dir_z = -(3 << 16);
        send_item(it, 1);
        it.drag_rate = 0;
        send_item(it, 1);
        it = '0; it.op = ppu_pkg::OPC_TICK; it.tick_time = 31'(1 << 16);
        send_item(it, 1);
        send_item(it, 1);
        // A huge step pushes the age past the lifetime and expires what is left.
        it.tick_time = 31'h7FFFFFFF;
        send_item(it, 0);
        drain();

        // Fill the pool past full, tick with a lifetime of zero to expire everything.
        write_reg(ppu_pkg::CFG_MAX_AGE, 32'h7FFFFFFF);
        for (int i = 0; i < 34; i++) send_item(spawn_item(), i != 33);
        send_item(tick_item(), 0);
        drain();
        write_reg(ppu_pkg::CFG_MAX_AGE, 32'd0);
        it = '0; it.op = ppu_pkg::OPC_TICK;
        send_item(it, 0);
        drain();

        // Random phases, each under its own register settings.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(ppu_pkg::CFG_MAX_AGE, {1'b0, ppu_pkg::MAX_AGE_RST});
                end
                1: begin
                    write_reg(ppu_pkg::CFG_MAX_AGE, 32'h7FFFFFFF);
                    write_reg(ppu_pkg::CFG_LEFT, 32'h80000000);
                    write_reg(ppu_pkg::CFG_RIGHT, 32'h7FFFFFFF);
                    write_reg(ppu_pkg::CFG_TOP, 32'h80000000);
                    write_reg(ppu_pkg::CFG_BOTTOM, 32'h7FFFFFFF);
                end
                2: begin
                    write_reg(ppu_pkg::CFG_MAX_AGE, 4 << 16);
                    write_reg(ppu_pkg::CFG_LEFT, 50 << 16);
                    write_reg(ppu_pkg::CFG_RIGHT, 250 << 16);
                    write_reg(ppu_pkg::CFG_TOP, 40 << 16);
                    write_reg(ppu_pkg::CFG_BOTTOM, 200 << 16);
                end
                3: begin
                    write_reg(ppu_pkg::CFG_MAX_AGE, $urandom);
                    write_reg(ppu_pkg::CFG_LEFT, -$urandom_range(0, 1 << 24));
                    write_reg(ppu_pkg::CFG_RIGHT, $urandom_range(1 << 22, 1 << 26));
                    write_reg(ppu_pkg::CFG_TOP, -$urandom_range(0, 1 << 24));
                    write_reg(ppu_pkg::CFG_BOTTOM, $urandom_range(1 << 22, 1 << 26));
                end
                default: begin
                    write_reg(ppu_pkg::CFG_MAX_AGE, {1'b0, ppu_pkg::MAX_AGE_RST});
                    write_reg(ppu_pkg::CFG_LEFT, ppu_pkg::LEFT_RST);
                    write_reg(ppu_pkg::CFG_RIGHT, ppu_pkg::RIGHT_RST);
                    write_reg(ppu_pkg::CFG_TOP, ppu_pkg::TOP_RST);
                    write_reg(ppu_pkg::CFG_BOTTOM, ppu_pkg::BOTTOM_RST);
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 5; ) begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst && n < RANDOM_ITEMS / 5; b++, n++) begin
                    // Mostly spawns, so that the pool fills and ticks have work to do.
                    if ($urandom_range(0, 2) == 0) it = tick_item();
                    else it = spawn_item();
                    send_item(it, b != burst - 1);
                end
                if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
            drain();
        end

        $display("covered %0d items (%0d ticks) giving %0d results across several settings",
                 items_sent, ticks_sent, result_count);
        if (fail_count == 0) begin
            $display("tb_particle_pool_update_unit: PASS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb_particle_pool_update_unit: FAIL");
        end
        $finish;
    end
endmodule
